// ===== rtl/core/csem_pkg.sv =====
// Package for the counting semaphore wait queue.
// Holds opcodes, status codes, controller states and control structs.
// No dependencies.
package csem_pkg;

  localparam int WaiterSlotsDefault = 16;
  localparam int TokW = 31;
  localparam int WcntW = 5;

  typedef enum logic [2:0] {
    OP_WAIT   = 3'd0,
    OP_POLL   = 3'd1,
    OP_SIGNAL = 3'd2,
    OP_CANCEL = 3'd3,
    OP_DELETE = 3'd4,
    OP_EXPIRE = 3'd5
  } op_t;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_BUSY      = 3'd1;
  localparam logic [2:0] ST_TIMEDOUT  = 3'd2;
  localparam logic [2:0] ST_INVALID   = 3'd3;
  localparam logic [2:0] ST_CANCELLED = 3'd4;
  localparam logic [2:0] ST_DELETED   = 3'd5;
  localparam logic [2:0] ST_QUEUED    = 3'd6;
  localparam logic [2:0] ST_FULL      = 3'd7;

  localparam logic [1:0] CFG_INITIAL = 2'd0;
  localparam logic [1:0] CFG_MAXIMUM = 2'd1;
  localparam logic [1:0] CFG_FIFO    = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_WALK,
    S_REPLY
  } state_t;

  // walk modes of the datapath
  typedef enum logic [1:0] {
    W_SIGNAL,
    W_RELEASE,
    W_EXPIRE,
    W_INSERT
  } walk_t;

  // controller to datapath
  typedef struct packed {
    logic  latch;      // capture the input item
    logic  decide;     // evaluate the immediate outcome
    logic  start_walk; // reset walk pointers
    logic  step;       // one walk step
    logic  finish;     // commit walk results
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic  need_walk;
    walk_t mode;
    logic  walk_done;
    logic  emit;       // current walk step yields a release
  } dp_stat_t;

endpackage

// ===== rtl/core/csem_datapath.sv =====
// Datapath of the counting semaphore: token count, waiter table, walk pointers.
// Depends on csem_pkg. The table is walked one entry per cycle while the receiver does not hold off a result.
module csem_datapath import csem_pkg::*; #(
  parameter int WAITER_SLOTS = WaiterSlotsDefault
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [TokW-1:0]     cfg_data,
  input  logic [2:0]          opcode,
  input  logic [TokW-1:0]     count,
  input  logic                use_initial,
  input  logic                zero_timeout,
  input  logic [7:0]          waiter_id,
  input  logic [7:0]          priority_req,
  input  dp_cmd_t             cmd,
  output dp_stat_t            stat,
  output logic [7:0]          rel_tag,
  output logic [2:0]          rel_status,
  output logic [7:0]          rep_tag,
  output logic [2:0]          rep_status,
  output logic [WcntW-1:0]    rep_wcount
);

  localparam int IW = (WAITER_SLOTS > 1) ? $clog2(WAITER_SLOTS) : 1;
  localparam int CW = $clog2(WAITER_SLOTS + 1);
  localparam int EW = TokW + 16;

  logic [TokW-1:0] initial_tokens, maximum_tokens;
  logic            fifo_mode;
  logic [TokW-1:0] tokens;
  logic [CW-1:0]   waiter_total;
  logic [EW-1:0]   table_q [WAITER_SLOTS];

  logic [2:0]      op_q;
  logic [TokW-1:0] cnt_q;
  logic            usei_q, zt_q;
  logic [7:0]      id_q, pr_q;

  logic [CW-1:0]   rd, wr;
  logic            found;
  logic [2:0]      status_q;
  logic [WcntW-1:0] wcount_q;
  logic            need_walk_q;
  walk_t           mode_q;
  logic [EW-1:0]   carry; // entry moved along during insert

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      initial_tokens <= '0;
      maximum_tokens <= TokW'(1);
      fifo_mode <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_INITIAL: initial_tokens <= cfg_data;
        CFG_MAXIMUM: maximum_tokens <= cfg_data;
        CFG_FIFO:    fifo_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // current entry fields
  logic [EW-1:0]   cur;
  logic [TokW-1:0] cur_need;
  logic [7:0]      cur_id, cur_pr;
  logic            in_range;
  logic [IW-1:0]   rd_i, wr_i;
  assign rd_i = rd[IW-1:0];
  assign wr_i = wr[IW-1:0];
  assign in_range = rd < waiter_total;
  assign cur = table_q[rd_i];
  assign cur_need = cur[EW-1:16];
  assign cur_id = cur[15:8];
  assign cur_pr = cur[7:0];

  logic fits;
  assign fits = cur_need <= tokens;

  logic [TokW:0] sig_sum;
  assign sig_sum = {1'b0, tokens} + {1'b0, cnt_q};

  // insert: position found at the table end, or outside fifo mode at the first entry whose priority is not higher
  logic ins_here;
  assign ins_here = !found && (!in_range || fifo_mode ? !in_range : !(cur_pr > pr_q));

  always_comb begin
    stat.need_walk = need_walk_q;
    stat.mode = mode_q;
    stat.emit = 1'b0;
    stat.walk_done = 1'b0;
    case (mode_q)
      W_SIGNAL: begin
        stat.walk_done = !in_range;
        stat.emit = in_range && fits;
      end
      W_RELEASE: begin
        stat.walk_done = !in_range;
        stat.emit = in_range;
      end
      W_EXPIRE: begin
        // keep walking after the match to close the gap
        stat.walk_done = !in_range;
        stat.emit = in_range && !found && cur_id == id_q;
      end
      W_INSERT: begin
        stat.walk_done = rd > waiter_total;
      end
      default: ;
    endcase
  end

  assign rel_tag = cur_id;
  always_comb begin
    case (mode_q)
      W_SIGNAL: rel_status = ST_OK;
      W_EXPIRE: rel_status = ST_TIMEDOUT;
      default:  rel_status = (op_q == OP_CANCEL) ? ST_CANCELLED : ST_DELETED;
    endcase
  end
  assign rep_tag = id_q;
  assign rep_status = status_q;
  assign rep_wcount = wcount_q;

  // control and token state
  always_ff @(posedge clk) begin
    if (rst) begin
      tokens <= '0;
      waiter_total <= '0;
      need_walk_q <= 1'b0;
      mode_q <= W_SIGNAL;
    end else begin
      if (cmd.decide) begin
        need_walk_q <= 1'b0;
        wcount_q <= '0;
        status_q <= ST_INVALID;
        case (op_q)
          OP_WAIT, OP_POLL: begin
            if (tokens >= cnt_q) begin
              tokens <= tokens - cnt_q;
              status_q <= ST_OK;
            end else if (op_q == OP_POLL) status_q <= ST_BUSY;
            else if (zt_q) status_q <= ST_TIMEDOUT;
            else if (waiter_total >= CW'(WAITER_SLOTS)) status_q <= ST_FULL;
            else begin
              status_q <= ST_QUEUED;
              need_walk_q <= 1'b1;
              mode_q <= W_INSERT;
            end
          end
          OP_SIGNAL: begin
            if (sig_sum <= {1'b0, maximum_tokens}) begin
              tokens <= sig_sum[TokW-1:0];
              status_q <= ST_OK;
              need_walk_q <= 1'b1;
              mode_q <= W_SIGNAL;
            end
          end
          OP_CANCEL: begin
            wcount_q <= WcntW'(waiter_total);
            tokens <= usei_q ? initial_tokens : cnt_q;
            status_q <= ST_OK;
            need_walk_q <= 1'b1;
            mode_q <= W_RELEASE;
          end
          OP_DELETE: begin
            status_q <= ST_OK;
            need_walk_q <= 1'b1;
            mode_q <= W_RELEASE;
          end
          OP_EXPIRE: begin
            need_walk_q <= 1'b1;
            mode_q <= W_EXPIRE;
          end
          default: ;
        endcase
      end
      if (cmd.step && mode_q == W_SIGNAL && in_range && fits)
        tokens <= tokens - cur_need;
      if (cmd.step && mode_q == W_EXPIRE && stat.emit) status_q <= ST_OK;
      if (cmd.finish) begin
        case (mode_q)
          W_SIGNAL:  waiter_total <= wr;
          W_RELEASE: waiter_total <= '0;
          W_EXPIRE:  if (found) waiter_total <= waiter_total - CW'(1);
          W_INSERT:  waiter_total <= waiter_total + CW'(1);
          default: ;
        endcase
      end
    end
  end

  // walk pointers and input capture
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_q <= opcode; cnt_q <= count; usei_q <= use_initial;
      zt_q <= zero_timeout; id_q <= waiter_id; pr_q <= priority_req;
    end
    if (cmd.start_walk) begin
      rd <= '0; wr <= '0; found <= 1'b0;
    end else if (cmd.step) begin
      rd <= rd + CW'(1);
      case (mode_q)
        W_SIGNAL: if (in_range && !fits) wr <= wr + CW'(1);
        W_EXPIRE: if (stat.emit) found <= 1'b1;
        W_INSERT: if (ins_here) found <= 1'b1;
        default: ;
      endcase
    end
  end

  // waiter table: one write per step
  always_ff @(posedge clk) begin
    if (cmd.step) begin
      case (mode_q)
        W_SIGNAL: if (in_range && !fits) table_q[wr_i] <= cur;
        W_EXPIRE: if (found && in_range && rd > CW'(0))
          table_q[IW'(rd - CW'(1))] <= cur;
        W_INSERT: begin
          if (rd < CW'(WAITER_SLOTS)) begin
            if (ins_here) table_q[rd_i] <= {cnt_q, id_q, pr_q};
            else if (found) table_q[rd_i] <= carry;
          end
          carry <= cur;
        end
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/core/csem_ctrl.sv =====
// Controller state machine of the counting semaphore.
// Depends on csem_pkg. Sequences capture, decision, walk and reply.
module csem_ctrl import csem_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  output logic     out_kind,
  output logic     out_last,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd = '0;
    in_ready = 1'b0;
    out_valid = 1'b0;
    out_kind = 1'b0;
    out_last = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch = 1'b1;
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        cmd.decide = 1'b1;
        cmd.start_walk = 1'b1;
        state_next = S_WALK;
      end
      S_WALK: begin
        if (!stat.need_walk) state_next = S_REPLY;
        else if (stat.walk_done) begin
          cmd.finish = 1'b1;
          state_next = S_REPLY;
        end else if (stat.emit && stat.mode != W_INSERT) begin
          out_valid = 1'b1;
          out_kind = 1'b1;
          if (out_ready) cmd.step = 1'b1;
        end else cmd.step = 1'b1;
      end
      S_REPLY: begin
        out_valid = 1'b1;
        out_last = 1'b1;
        if (out_ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// ===== rtl/core/counting_semaphore_wait_queue.sv =====
// Counting semaphore with a bounded, ordered waiter table.
// Input channel in_valid/in_ready carries one item (opcode and operands).
// Output channel out_valid/out_ready carries results: releases of queued
// waiters in queue order (kind=1), then one reply (kind=0, last=1).
// Configuration: cfg_we, cfg_index, cfg_data.
// One item at a time: capture, decide, a table walk over up to
// WAITER_SLOTS entries, one per step, that waits while the receiver
// holds off a result, then the reply. A busy or immediate item skips
// the walk; a full signal walk visits every queued waiter.
// The walk through the waiter table dominates the time per item.
// Reset clears tokens and the waiter count; table contents need none.
// A stalled receiver freezes the walk at the pending result; no result
// is lost or repeated. in_ready is high only between items.
module counting_semaphore_wait_queue import csem_pkg::*; #(
  parameter int WAITER_SLOTS = WaiterSlotsDefault
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [TokW-1:0]  cfg_data,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [2:0]       opcode,
  input  logic [TokW-1:0]  count,
  input  logic             use_initial,
  input  logic             zero_timeout,
  input  logic [7:0]       waiter_id,
  input  logic [7:0]       priority_req,
  output logic             out_valid,
  input  logic             out_ready,
  output logic             kind,
  output logic [7:0]       waiter_tag,
  output logic [2:0]       status,
  output logic [WcntW-1:0] waiter_count,
  output logic             last
);

  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic [7:0] rel_tag, rep_tag;
  logic [2:0] rel_status, rep_status;
  logic [WcntW-1:0] rep_wcount;

  csem_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_ready, .out_valid, .out_ready,
    .out_kind(kind), .out_last(last), .stat, .cmd
  );

  csem_datapath #(.WAITER_SLOTS(WAITER_SLOTS)) u_dp (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data, .opcode, .count,
    .use_initial, .zero_timeout, .waiter_id, .priority_req, .cmd, .stat,
    .rel_tag, .rel_status, .rep_tag, .rep_status, .rep_wcount
  );

  // result mux
  assign waiter_tag   = kind ? rel_tag : rep_tag;
  assign status       = kind ? rel_status : rep_status;
  assign waiter_count = kind ? '0 : rep_wcount;

endmodule

// ===== rtl/core/csem_checker.sv =====
// Port-level checks for the counting semaphore.
// Depends on csem_pkg; bound to counting_semaphore_wait_queue.
module csem_checker import csem_pkg::*; (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic kind,
  input logic last,
  input logic [2:0] status
);

  // releases are never marked last; replies always are
  a_last: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (kind != last)) else $error("kind/last mismatch");

  // no new item while results are pending
  a_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready) else $error("input taken while busy");

  // after the reply is taken the block is ready again
  a_ready: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && last) |=> in_ready) else $error("not ready");

  // a release never carries queued or full status
  a_rel: assert property (@(posedge clk) disable iff (rst)
    (out_valid && kind) |-> (status != ST_QUEUED && status != ST_FULL))
    else $error("bad release status");

endmodule

bind counting_semaphore_wait_queue csem_checker u_chk (
  .clk, .rst, .in_valid, .in_ready, .out_valid, .out_ready,
  .kind, .last, .status
);
